@@ rtl/kes_pkg.sv @@
package kes_pkg;

	localparam int FRAC_BITS     = 28;
	localparam int ANG_W         = 32;
	localparam int M_W           = 31;
	localparam int ECC_W         = 32;
	localparam int ITER_W        = 6;
	localparam int TOL_W         = 16;
	localparam int CFG_W         = 16;
	localparam int CW            = 34;
	localparam int RW            = 36;
	localparam int PROD_W        = 67;
	localparam int F_W           = 34;
	localparam int D_W           = 64;
	localparam int Q_W           = 63;
	localparam int CORDIC_STAGES = 30;
	localparam int IDX_W         = 5;
	localparam int DIV_STEPS     = 96;
	localparam int DIV_W         = 7;
	localparam int DIV_SHIFT     = 62;
	localparam int ES_SHIFT      = 62 - FRAC_BITS;

	localparam logic [ITER_W-1:0] MAX_ITER_RST = 6'd50;
	localparam logic [TOL_W-1:0]  TOL_RST      = 16'd4;

	localparam logic CFG_MAX_ITER = 1'b0;
	localparam logic CFG_TOL      = 1'b1;

	localparam logic [ECC_W-1:0]        ECC_THRESH  = 32'd3435973836;
	localparam logic signed [ANG_W-1:0] PI_FIX      = 32'sd843314857;
	localparam logic signed [ANG_W-1:0] ANG_MAX     = 32'sh7FFFFFFF;
	localparam logic signed [ANG_W-1:0] ANG_MIN     = 32'sh80000000;
	localparam logic signed [RW-1:0]    PI_Q30      = 36'sd3373259426;
	localparam logic signed [RW-1:0]    HALF_PI_Q30 = 36'sd1686629713;
	localparam logic signed [RW-1:0]    TWO_PI_Q30  = 36'sd6746518852;
	localparam logic signed [CW-1:0]    CORDIC_K    = 34'sd652032874;
	localparam logic [D_W-1:0]          ONE_Q62     = 64'h4000000000000000;

	typedef struct packed {
		logic             load;
		logic             cinit;
		logic             cstep;
		logic [IDX_W-1:0] cidx;
		logic             mul_s;
		logic             mul_c;
		logic             check;
		logic             dstep;
		logic [DIV_W-1:0] dbit;
		logic             update;
		logic             emit;
	} kes_cmd_t;

	typedef struct packed {
		logic pass;
	} kes_stat_t;

	function automatic logic signed [CW-1:0] atan_q30(input logic [IDX_W-1:0] i);
		logic signed [CW-1:0] v;
		case (i)
			5'd0:  v = 34'sd843314856;
			5'd1:  v = 34'sd497837829;
			5'd2:  v = 34'sd263043836;
			5'd3:  v = 34'sd133525158;
			5'd4:  v = 34'sd67021686;
			5'd5:  v = 34'sd33543515;
			5'd6:  v = 34'sd16775850;
			5'd7:  v = 34'sd8388437;
			5'd8:  v = 34'sd4194282;
			5'd9:  v = 34'sd2097149;
			5'd10: v = 34'sd1048575;
			5'd11: v = 34'sd524287;
			5'd12: v = 34'sd262143;
			5'd13: v = 34'sd131071;
			5'd14: v = 34'sd65535;
			5'd15: v = 34'sd32767;
			5'd16: v = 34'sd16383;
			5'd17: v = 34'sd8191;
			5'd18: v = 34'sd4095;
			5'd19: v = 34'sd2047;
			5'd20: v = 34'sd1023;
			5'd21: v = 34'sd511;
			5'd22: v = 34'sd255;
			5'd23: v = 34'sd127;
			5'd24: v = 34'sd63;
			5'd25: v = 34'sd31;
			5'd26: v = 34'sd15;
			5'd27: v = 34'sd8;
			5'd28: v = 34'sd4;
			5'd29: v = 34'sd2;
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

@@ rtl/kes_dp.sv @@
module kes_dp (
	input  logic                       clk,
	input  kes_pkg::kes_cmd_t          cmd,
	output kes_pkg::kes_stat_t         stat,
	input  logic [kes_pkg::M_W-1:0]    mean_anomaly,
	input  logic [kes_pkg::ECC_W-1:0]  eccentricity,
	input  logic [kes_pkg::TOL_W-1:0]  tolerance_lsb,
	output logic signed [kes_pkg::ANG_W-1:0] ecc_anomaly
);
	import kes_pkg::*;

	logic [M_W-1:0]          m_q;
	logic [ECC_W-1:0]        ecc_q;
	logic signed [ANG_W-1:0] e_q;
	logic signed [CW-1:0]    x_q, y_q, z_q;
	logic                    flip_q;
	logic signed [PROD_W-1:0] ps_q, pc_q;
	logic signed [F_W-1:0]   f_q;
	logic [D_W-1:0]          d_q;
	logic [F_W-1:0]          num_q;
	logic [D_W-1:0]          r_q;
	logic [Q_W-1:0]          q_q;
	logic                    sat_q;
	logic signed [ANG_W-1:0] ecc_anomaly_q;

	logic signed [RW-1:0]    zw, z1, z2;
	logic                    fl;
	logic signed [CW-1:0]    dx, dy, cval, op;
	logic signed [PROD_W-1:0] prod;
	logic signed [F_W-1:0]   es, f_nx;
	logic [F_W-1:0]          fmag;
	logic signed [PROD_W-1:0] ec_mag;
	logic [D_W-1:0]          d_nx;
	logic                    nbit;
	logic [DIV_W-1:0]        nsel;
	logic [D_W:0]            r_sh;
	logic                    qb;
	logic [Q_W-1:0]          q_nx;
	logic [Q_W-1:0]          q_eff;
	logic signed [D_W-1:0]   e64, t64;
	logic signed [ANG_W-1:0] e_nx;

	always_comb begin
		zw = RW'($signed({e_q, 2'b00}));
		if (zw > PI_Q30)
			z1 = zw - TWO_PI_Q30;
		else if (zw < -PI_Q30)
			z1 = zw + TWO_PI_Q30;
		else
			z1 = zw;
		fl = 1'b0;
		if (z1 > HALF_PI_Q30) begin
			z2 = PI_Q30 - z1;
			fl = 1'b1;
		end else if (z1 < -HALF_PI_Q30) begin
			z2 = -PI_Q30 - z1;
			fl = 1'b1;
		end else begin
			z2 = z1;
		end
	end

	assign dx   = y_q >>> cmd.cidx;
	assign dy   = x_q >>> cmd.cidx;
	assign cval = flip_q ? -x_q : x_q;
	assign op   = cmd.mul_s ? y_q : cval;
	assign prod = $signed({1'b0, ecc_q}) * op;

	assign es   = F_W'(ps_q >>> ES_SHIFT);
	assign f_nx = F_W'(e_q) - es - $signed(F_W'(m_q));
	assign fmag = f_q[F_W-1] ? F_W'(-f_q) : F_W'(f_q);
	assign stat.pass = fmag < F_W'(tolerance_lsb);

	always_comb begin
		ec_mag = -pc_q;
		if (!pc_q[PROD_W-1]) begin
			if (pc_q < $signed(PROD_W'(ONE_Q62)))
				d_nx = ONE_Q62 - D_W'(pc_q);
			else
				d_nx = D_W'(1);
		end else begin
			d_nx = ONE_Q62 + D_W'(ec_mag);
		end
	end

	always_comb begin
		nsel = cmd.dbit - DIV_W'(DIV_SHIFT);
		nbit = (cmd.dbit >= DIV_W'(DIV_SHIFT)) ? num_q[nsel[5:0]] : 1'b0;
		r_sh = {r_q, nbit};
		qb   = r_sh >= {1'b0, d_q};
		q_nx = sat_q ? q_q : {q_q[Q_W-2:0], qb};
	end

	assign q_eff = sat_q ? Q_W'(ONE_Q62) : q_q;

	always_comb begin
		e64 = D_W'(e_q);
		if (!f_q[F_W-1] && (f_q != '0)) begin
			t64  = e64 - $signed({1'b0, q_eff});
			e_nx = (t64 < D_W'(ANG_MIN)) ? ANG_MIN : t64[ANG_W-1:0];
		end else begin
			t64  = e64 + $signed({1'b0, q_eff});
			e_nx = (t64 > D_W'(ANG_MAX)) ? ANG_MAX : t64[ANG_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			m_q   <= mean_anomaly;
			ecc_q <= eccentricity;
			e_q   <= (eccentricity > ECC_THRESH) ? PI_FIX : $signed({1'b0, mean_anomaly});
		end
		if (cmd.cinit) begin
			x_q    <= CORDIC_K;
			y_q    <= '0;
			z_q    <= z2[CW-1:0];
			flip_q <= fl;
		end
		if (cmd.cstep) begin
			if (!z_q[CW-1]) begin
				x_q <= x_q - dx;
				y_q <= y_q + dy;
				z_q <= z_q - atan_q30(cmd.cidx);
			end else begin
				x_q <= x_q + dx;
				y_q <= y_q - dy;
				z_q <= z_q + atan_q30(cmd.cidx);
			end
		end
		if (cmd.mul_s)
			ps_q <= prod;
		if (cmd.mul_c) begin
			pc_q <= prod;
			f_q  <= f_nx;
		end
		if (cmd.check) begin
			d_q   <= d_nx;
			num_q <= fmag;
			r_q   <= '0;
			q_q   <= '0;
			sat_q <= 1'b0;
		end
		if (cmd.dstep) begin
			r_q   <= qb ? D_W'(r_sh - {1'b0, d_q}) : r_sh[D_W-1:0];
			q_q   <= q_nx;
			sat_q <= sat_q | q_nx[Q_W-1];
		end
		if (cmd.update)
			e_q <= e_nx;
		if (cmd.emit)
			ecc_anomaly_q <= e_q;
	end

	assign ecc_anomaly = ecc_anomaly_q;

endmodule

@@ rtl/kes_ctrl.sv @@
module kes_ctrl (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	output logic                        out_valid,
	input  logic                        out_ready,
	input  logic [kes_pkg::ITER_W-1:0]  max_iterations,
	input  kes_pkg::kes_stat_t          stat,
	output kes_pkg::kes_cmd_t           cmd,
	output logic [kes_pkg::ITER_W-1:0]  steps_used,
	output logic                        converged
);
	import kes_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE, ST_CINIT, ST_CORDIC, ST_MULS, ST_MULC,
		ST_CHECK, ST_DIV, ST_UPD, ST_EMIT
	} state_t;

	state_t            state_q;
	logic [IDX_W-1:0]  cidx_q;
	logic [DIV_W-1:0]  dbit_q;
	logic [ITER_W-1:0] steps_q;
	logic              conv_q;
	logic              out_valid_q;
	logic [ITER_W-1:0] steps_used_q;
	logic              converged_q;
	logic              emit;
	logic [ITER_W-1:0] steps_inc;

	assign in_ready  = state_q == ST_IDLE;
	assign emit      = (state_q == ST_EMIT) && (!out_valid_q || out_ready);
	assign steps_inc = steps_q + ITER_W'(1);

	always_comb begin
		cmd        = '0;
		cmd.cidx   = cidx_q;
		cmd.dbit   = dbit_q;
		cmd.load   = in_ready && in_valid;
		cmd.cinit  = state_q == ST_CINIT;
		cmd.cstep  = state_q == ST_CORDIC;
		cmd.mul_s  = state_q == ST_MULS;
		cmd.mul_c  = state_q == ST_MULC;
		cmd.check  = state_q == ST_CHECK;
		cmd.dstep  = state_q == ST_DIV;
		cmd.update = state_q == ST_UPD;
		cmd.emit   = emit;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			cidx_q       <= '0;
			dbit_q       <= '0;
			steps_q      <= '0;
			conv_q       <= 1'b0;
			out_valid_q  <= 1'b0;
			steps_used_q <= '0;
			converged_q  <= 1'b0;
		end else begin
			if (out_valid_q && out_ready && !emit)
				out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						steps_q <= '0;
						conv_q  <= 1'b0;
						state_q <= (max_iterations == '0) ? ST_EMIT : ST_CINIT;
					end
				end
				ST_CINIT: begin
					cidx_q  <= '0;
					state_q <= ST_CORDIC;
				end
				ST_CORDIC: begin
					if (cidx_q == IDX_W'(CORDIC_STAGES - 1))
						state_q <= ST_MULS;
					else
						cidx_q <= cidx_q + IDX_W'(1);
				end
				ST_MULS: state_q <= ST_MULC;
				ST_MULC: state_q <= ST_CHECK;
				ST_CHECK: begin
					if (stat.pass) begin
						conv_q  <= 1'b1;
						state_q <= ST_EMIT;
					end else begin
						dbit_q  <= DIV_W'(DIV_STEPS - 1);
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (dbit_q == '0)
						state_q <= ST_UPD;
					else
						dbit_q <= dbit_q - DIV_W'(1);
				end
				ST_UPD: begin
					steps_q <= steps_inc;
					state_q <= (steps_inc == max_iterations) ? ST_EMIT : ST_CINIT;
				end
				ST_EMIT: begin
					if (emit) begin
						out_valid_q  <= 1'b1;
						steps_used_q <= steps_q;
						converged_q  <= conv_q;
						state_q      <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid  = out_valid_q;
	assign steps_used = steps_used_q;
	assign converged  = converged_q;

	a_cidx_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_CORDIC |-> cidx_q < IDX_W'(CORDIC_STAGES))
		else $error("rotation index out of range");

	a_steps_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_IDLE |-> steps_q <= max_iterations)
		else $error("step count above limit");

	a_conv_steps: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && converged_q |-> steps_used_q < max_iterations)
		else $error("converged word reports limit reached");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> state_q != ST_IDLE)
		else $error("accepted word did not start");

endmodule

@@ rtl/kepler_equation_solver_unit.sv @@
// A word ends when the residual check passes or when the step limit is reached, after N
// Newton updates (0..63); each update is 1 setup + 30 CORDIC rotations + 2 multiplies + 1 check
// + 96 divide bits + 1 update, all on one shared rotator, multiplier and restoring divider.
// A new word is taken only once the previous result has been emitted; the next word is taken
// while that result waits for out_ready.
// Reset: arst_n asynchronous active low; clears control and loads register defaults
// (max_iterations 50, tolerance_lsb 4).
module kepler_equation_solver_unit (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_wr_en,
	input  logic                             cfg_index,
	input  logic [kes_pkg::CFG_W-1:0]        cfg_wdata,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [kes_pkg::M_W-1:0]          mean_anomaly,
	input  logic [kes_pkg::ECC_W-1:0]        eccentricity,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic signed [kes_pkg::ANG_W-1:0] ecc_anomaly,
	output logic [kes_pkg::ITER_W-1:0]       steps_used,
	output logic                             converged
);
	import kes_pkg::*;

	logic [ITER_W-1:0] max_iter_q;
	logic [TOL_W-1:0]  tol_q;
	kes_cmd_t          cmd;
	kes_stat_t         stat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_iter_q <= MAX_ITER_RST;
			tol_q      <= TOL_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				CFG_MAX_ITER: max_iter_q <= cfg_wdata[ITER_W-1:0];
				CFG_TOL:      tol_q      <= cfg_wdata[TOL_W-1:0];
				default:      ;
			endcase
		end
	end

	kes_ctrl u_ctrl (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.max_iterations (max_iter_q),
		.stat           (stat),
		.cmd            (cmd),
		.steps_used     (steps_used),
		.converged      (converged)
	);

	kes_dp u_dp (
		.clk           (clk),
		.cmd           (cmd),
		.stat          (stat),
		.mean_anomaly  (mean_anomaly),
		.eccentricity  (eccentricity),
		.tolerance_lsb (tol_q),
		.ecc_anomaly   (ecc_anomaly)
	);

endmodule
